>>> rtl/lmcs_pkg.sv
// ----------------------------------------------------------------------------
// lmcs_pkg
// Shared types and constants for the LED matrix column scroller.
// ----------------------------------------------------------------------------
package lmcs_pkg;

    localparam int unsigned NUM_COLS  = 8;
    localparam int unsigned NUM_ROWS  = 8;
    localparam int unsigned ROW_W     = 8;
    localparam int unsigned COUNT_W   = 6;

    localparam logic [COUNT_W-1:0] LAST_COUNT = 6'd63;
    localparam logic [2:0]         LAST_COL   = 3'd7;

    typedef logic [ROW_W-1:0] row_t;
    typedef row_t [NUM_ROWS-1:0] glyph_t;

    // glyph row shifter control
    typedef struct packed {
        logic load;
        logic shift;
    } glyph_ctrl_t;

    // column ring control
    typedef struct packed {
        logic advance;
        logic clear;
    } ring_ctrl_t;

endpackage

>>> rtl/lmcs_glyph_shift.sv
// ----------------------------------------------------------------------------
// lmcs_glyph_shift
// Holds the glyph rows and shifts them left one bit per scroll step; the
// top bit of every row forms the column that enters the display next.
// ----------------------------------------------------------------------------
module lmcs_glyph_shift (
    input  logic                  aclk,
    input  lmcs_pkg::glyph_ctrl_t ctrl,
    input  lmcs_pkg::glyph_t      glyph_in,
    output lmcs_pkg::row_t        new_column
);

    lmcs_pkg::glyph_t rows_reg;
    lmcs_pkg::glyph_t rows_next;

    // load a fresh glyph or move every row one bit toward the msb
    always_comb begin
        rows_next = rows_reg;
        if (ctrl.load) begin
            rows_next = glyph_in;
        end else if (ctrl.shift) begin
            for (int r = 0; r < lmcs_pkg::NUM_ROWS; r++) begin
                rows_next[r] = {rows_reg[r][lmcs_pkg::ROW_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        rows_reg <= rows_next;
    end

    // bit b of the column is the leftmost remaining bit of row b
    always_comb begin
        for (int b = 0; b < lmcs_pkg::NUM_ROWS; b++) begin
            new_column[b] = rows_reg[b][lmcs_pkg::ROW_W-1];
        end
    end

endmodule

>>> rtl/lmcs_col_ring.sv
// ----------------------------------------------------------------------------
// lmcs_col_ring
// Eight-column display buffer kept as a rotating ring. Each output transfer
// moves the ring by one column and feeds the written byte in at the tail,
// so eight transfers leave the scrolled buffer in place.
// ----------------------------------------------------------------------------
module lmcs_col_ring (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  lmcs_pkg::ring_ctrl_t ctrl,
    input  lmcs_pkg::row_t       tail_in,
    output lmcs_pkg::row_t       second_col
);

    lmcs_pkg::row_t [lmcs_pkg::NUM_COLS-1:0] ring_reg;
    lmcs_pkg::row_t [lmcs_pkg::NUM_COLS-1:0] ring_next;

    // rotate by one column, or blank the display after a final character
    always_comb begin
        ring_next = ring_reg;
        if (ctrl.clear) begin
            ring_next = '0;
        end else if (ctrl.advance) begin
            for (int c = 0; c < lmcs_pkg::NUM_COLS - 1; c++) begin
                ring_next[c] = ring_reg[c+1];
            end
            ring_next[lmcs_pkg::NUM_COLS-1] = tail_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ring_reg <= '0;
        end else begin
            ring_reg <= ring_next;
        end
    end

    // the head column is the one that scrolls off, so writes start one further in
    assign second_col = ring_reg[1];

endmodule

>>> rtl/led_matrix_column_scroller_top.sv
// ----------------------------------------------------------------------------
// led_matrix_column_scroller_top
// Scrolls an 8x8 glyph into an eight-column display buffer and emits the
// 64 digit writes (eight per scroll step) that show each step.
// The first write is valid in the cycle after the glyph transfer.
// Throughput: one write per cycle while m_ready is high; the next glyph is
// taken on the same edge as the last write.
// Reset: synchronous active-low aresetn; buffer cleared, block idle.
// ----------------------------------------------------------------------------
module led_matrix_column_scroller_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_glyph_row_0,
    input  logic [7:0] s_glyph_row_1,
    input  logic [7:0] s_glyph_row_2,
    input  logic [7:0] s_glyph_row_3,
    input  logic [7:0] s_glyph_row_4,
    input  logic [7:0] s_glyph_row_5,
    input  logic [7:0] s_glyph_row_6,
    input  logic [7:0] s_glyph_row_7,
    input  logic       s_final_char,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [3:0] m_digit_address,
    output logic [7:0] m_column_data,
    output logic       m_last_write
);

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t                          state_reg;
    state_t                          state_next;
    logic [lmcs_pkg::COUNT_W-1:0]    count_reg;
    logic [lmcs_pkg::COUNT_W-1:0]    count_next;
    logic                            final_reg;
    logic                            final_next;

    logic                  in_xfer;
    logic                  out_xfer;
    logic                  last_count;
    logic [2:0]            col_idx;
    lmcs_pkg::glyph_t      glyph_in;
    lmcs_pkg::glyph_ctrl_t glyph_ctrl;
    lmcs_pkg::ring_ctrl_t  ring_ctrl;
    lmcs_pkg::row_t        new_column;
    lmcs_pkg::row_t        second_col;

    // handshake
    assign col_idx    = count_reg[2:0];
    assign last_count = (count_reg == lmcs_pkg::LAST_COUNT);
    assign m_valid    = (state_reg == ST_SCAN);
    assign s_ready    = (state_reg == ST_IDLE) || (m_ready && last_count);
    assign in_xfer    = s_valid && s_ready;
    assign out_xfer   = m_valid && m_ready;

    assign glyph_in = {s_glyph_row_7, s_glyph_row_6, s_glyph_row_5, s_glyph_row_4,
                       s_glyph_row_3, s_glyph_row_2, s_glyph_row_1, s_glyph_row_0};

    // datapath control
    always_comb begin
        glyph_ctrl.load   = in_xfer;
        glyph_ctrl.shift  = out_xfer && (col_idx == lmcs_pkg::LAST_COL);
        ring_ctrl.advance = out_xfer;
        ring_ctrl.clear   = out_xfer && last_count && final_reg;
    end

    lmcs_glyph_shift u_glyph (
        .aclk       (aclk),
        .ctrl       (glyph_ctrl),
        .glyph_in   (glyph_in),
        .new_column (new_column)
    );

    lmcs_col_ring u_ring (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ring_ctrl),
        .tail_in    (m_column_data),
        .second_col (second_col)
    );

    // write payload: last column of each step is the freshly built one
    assign m_column_data   = (col_idx == lmcs_pkg::LAST_COL) ? new_column : second_col;
    assign m_digit_address = {1'b0, col_idx} + 4'd1;
    assign m_last_write    = last_count;

    // sequencer next state
    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        final_next = final_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    state_next = ST_SCAN;
                    count_next = '0;
                    final_next = s_final_char;
                end
            end
            ST_SCAN: begin
                if (out_xfer) begin
                    count_next = count_reg + 1'b1;
                    if (last_count) begin
                        state_next = ST_IDLE;
                    end
                end
                if (in_xfer) begin
                    state_next = ST_SCAN;
                    count_next = '0;
                    final_next = s_final_char;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            final_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            final_reg <= final_next;
        end
    end

endmodule

>>> rtl/lmcs_checker.sv
// ----------------------------------------------------------------------------
// lmcs_checker
// Port-level checks for the column scroller, bound to the top level.
// ----------------------------------------------------------------------------
module lmcs_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [3:0] m_digit_address,
    input logic [7:0] m_column_data,
    input logic       m_last_write
);

    // a stalled write holds its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_digit_address)
            && $stable(m_column_data) && $stable(m_last_write))
        else $error("stalled write changed");

    // no new glyph while a glyph still has writes beyond the current one
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last_write |-> !s_ready)
        else $error("glyph taken mid scroll");

    // an accepted glyph produces a write next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid && (m_digit_address == 4'd1))
        else $error("glyph produced no write");

    // addresses step through the columns in order
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_write && (m_digit_address != 4'd8)
            |=> m_valid && (m_digit_address == $past(m_digit_address) + 4'd1))
        else $error("digit address out of sequence");

    // the flagged write is to the last column
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last_write |-> (m_digit_address == 4'd8))
        else $error("last write not on last column");

endmodule

bind led_matrix_column_scroller_top lmcs_checker u_lmcs_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_digit_address (m_digit_address),
    .m_column_data   (m_column_data),
    .m_last_write    (m_last_write)
);
